// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// check a property every clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// check a property every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/tls_pkg.sv =====
// Constants and state type for the text line sorter
package tls_pkg;
  localparam int MAX_LINES = 64;
  localparam int MAX_LEN   = 100;
  localparam int LINE_W    = $clog2(MAX_LINES);
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int LEN_W     = $clog2(MAX_LEN);
  localparam int ADDR_W    = $clog2(MAX_LINES * MAX_LEN);

  localparam logic [7:0] NL_BYTE = 8'd10;
  localparam logic [7:0] SP_BYTE = 8'd32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_NEXT_I,
    S_CHECK,
    S_RDA,
    S_LEN,
    S_BYTE,
    S_BCMP,
    S_DEC,
    S_EMIT_RD,
    S_SHOW
  } state_t;
endpackage

// ===== hdl/text_line_sorter.sv =====
// Text line sorter: buffers lines of a byte stream, then emits their sorted order
// The end marker starts an insertion sort run by one byte comparator: each line
// compare reads both lengths, then compares bytes in turn until one differs or
// the shorter line runs out; each result is read from the order store, then shown.
// Throughput: one text byte per cycle; no input is taken while sorting or emitting.
// Reset (synchronous, rst high) empties the line buffer; no memory clearing pass.
`include "assert_macros.svh"
module text_line_sorter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  text_byte,
  input  logic                        end_of_text,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tls_pkg::LINE_W-1:0]  line_number,
  output logic                        final_line,
  output logic                        lines_dropped
);
  import tls_pkg::*;

  state_t state, state_next;

  // memories
  logic [7:0]       text_mem [MAX_LINES*MAX_LEN];
  logic [LEN_W-1:0] len_mem  [MAX_LINES];
  logic [LINE_W-1:0] ord_mem [MAX_LINES];

  // load state
  logic [CNT_W-1:0]  line_total;
  logic              at_line_start;
  logic              overflow;
  logic [LEN_W-1:0]  cur_len;
  logic [ADDR_W-1:0] wbase;

  // sort state
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  i_cnt;
  logic [LINE_W-1:0] j_cnt;
  logic [LINE_W-1:0] a_idx;
  logic [ADDR_W-1:0] abase;
  logic [ADDR_W-1:0] keybase;
  logic [LEN_W-1:0]  la, lb, k_cnt;
  logic              after;
  logic [LINE_W-1:0] idx;

  // memory read data and addresses
  logic [7:0]        txt_a, txt_b;
  logic [LEN_W-1:0]  len_qa, len_qb;
  logic [LINE_W-1:0] ord_q;
  logic [LINE_W-1:0] ord_raddr;
  logic [LINE_W-1:0] key;
  logic [LEN_W-1:0]  n_min;

  logic in_acc, out_acc, full, is_last;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign full    = (line_total == CNT_W'(MAX_LINES));
  assign key     = i_cnt[LINE_W-1:0];
  assign n_min   = (la < lb) ? la : lb;
  assign is_last = ({1'b0, idx} + CNT_W'(1)) == count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:    if (in_acc && end_of_text) state_next = S_NEXT_I;
      S_NEXT_I:  state_next = (i_cnt == count) ? S_EMIT_RD : S_CHECK;
      S_CHECK:   state_next = (j_cnt == '0) ? S_NEXT_I : S_RDA;
      S_RDA:     state_next = S_LEN;
      S_LEN:     state_next = S_BYTE;
      S_BYTE:    state_next = (k_cnt == n_min) ? S_DEC : S_BCMP;
      S_BCMP:    state_next = (txt_a != txt_b) ? S_DEC : S_BYTE;
      S_DEC:     state_next = after ? S_CHECK : S_NEXT_I;
      S_EMIT_RD: state_next = S_SHOW;
      S_SHOW: begin
        if (out_acc) state_next = is_last ? S_LOAD : S_EMIT_RD;
      end
      default:   state_next = S_LOAD;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      S_LOAD:  in_stall = 1'b0;
      S_SHOW:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign line_number   = ord_q;
  assign final_line    = is_last;
  assign lines_dropped = overflow;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  // order memory read address: predecessor slot in the check state, else emit slot
  assign ord_raddr = (state == S_CHECK) ? (j_cnt - LINE_W'(1)) : idx;

  // memory reads
  always_ff @(posedge clk) begin
    ord_q  <= ord_mem[ord_raddr];
    len_qa <= len_mem[ord_q];
    len_qb <= len_mem[key];
    txt_a  <= text_mem[abase + ADDR_W'(k_cnt)];
    txt_b  <= text_mem[keybase + ADDR_W'(k_cnt)];
  end

  // text store write: keep bytes of the current line up to the length limit
  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_acc && !end_of_text && !full
        && !(at_line_start && text_byte == SP_BYTE)
        && cur_len < LEN_W'(MAX_LEN - 1)) begin
      text_mem[wbase + ADDR_W'(cur_len)] <= text_byte;
    end
  end

  // length store write: on line end and for the open line at the end marker
  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_acc && !full) begin
      if (end_of_text) begin
        len_mem[line_total[LINE_W-1:0]] <= cur_len;
      end else if (!(at_line_start && text_byte == SP_BYTE) && text_byte == NL_BYTE) begin
        len_mem[line_total[LINE_W-1:0]] <=
          (cur_len < LEN_W'(MAX_LEN - 1)) ? cur_len + LEN_W'(1) : cur_len;
      end
    end
  end

  // order store write: place the key or shift the predecessor up
  always_ff @(posedge clk) begin
    if (state == S_CHECK && j_cnt == '0) begin
      ord_mem[j_cnt] <= key;
    end else if (state == S_DEC) begin
      ord_mem[j_cnt] <= after ? a_idx : key;
    end
  end

  // load control
  always_ff @(posedge clk) begin
    if (rst) begin
      line_total    <= '0;
      at_line_start <= 1'b1;
      overflow      <= 1'b0;
      cur_len       <= '0;
      wbase         <= '0;
    end else if (state == S_LOAD && in_acc && !end_of_text && !full
                 && !(at_line_start && text_byte == SP_BYTE)) begin
      at_line_start <= 1'b0;
      if (cur_len < LEN_W'(MAX_LEN - 1)) cur_len <= cur_len + LEN_W'(1);
      if (text_byte == NL_BYTE) begin
        line_total    <= line_total + CNT_W'(1);
        wbase         <= wbase + ADDR_W'(MAX_LEN);
        cur_len       <= '0;
        at_line_start <= 1'b1;
        if (line_total + CNT_W'(1) >= CNT_W'(MAX_LINES)) overflow <= 1'b1;
      end
    end else if (state == S_SHOW && out_acc && is_last) begin
      // drop the finished text and start over
      line_total    <= '0;
      at_line_start <= 1'b1;
      overflow      <= 1'b0;
      cur_len       <= '0;
      wbase         <= '0;
    end
  end

  // sort and emit datapath
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (in_acc && end_of_text) begin
          count   <= full ? CNT_W'(MAX_LINES) : line_total + CNT_W'(1);
          i_cnt   <= '0;
          keybase <= '0;
        end
      end
      S_NEXT_I: begin
        j_cnt <= key;
        idx   <= '0;
      end
      S_CHECK: begin
        if (j_cnt == '0) begin
          i_cnt   <= i_cnt + CNT_W'(1);
          keybase <= keybase + ADDR_W'(MAX_LEN);
        end
      end
      S_RDA: begin
        a_idx <= ord_q;
        abase <= ADDR_W'(ord_q) * ADDR_W'(MAX_LEN);
      end
      S_LEN: begin
        la    <= len_qa;
        lb    <= len_qb;
        k_cnt <= '0;
      end
      S_BYTE: begin
        if (k_cnt == n_min) after <= (la > lb);
      end
      S_BCMP: begin
        if (txt_a != txt_b) after <= (txt_a > txt_b);
        else                k_cnt <= k_cnt + LEN_W'(1);
      end
      S_DEC: begin
        if (after) begin
          j_cnt <= j_cnt - LINE_W'(1);
        end else begin
          i_cnt   <= i_cnt + CNT_W'(1);
          keybase <= keybase + ADDR_W'(MAX_LEN);
        end
      end
      S_SHOW: begin
        if (out_acc && !is_last) idx <= idx + LINE_W'(1);
      end
      default: ;
    endcase
  end

  // assertions
  `ASSERT_CLK(a_total_bound, line_total <= CNT_W'(MAX_LINES))
  `ASSERT_CLK(a_no_input_while_emit, out_valid |-> in_stall)
  `ASSERT_CLK(a_marker_blocks, (in_valid && !in_stall && end_of_text) |=> in_stall)
  `ASSERT_CLK(a_clear_after_run, (out_valid && !out_stall && final_line) |=> (line_total == '0 && !lines_dropped))
endmodule
